// ===== src/bsc_pkg.sv =====
// Shared types, constants and helpers for the barometric compensation pipeline.
package bsc_pkg;

   localparam int DivBits = 32;

   localparam logic [1:0] RegTempCalib = 2'd0;
   localparam logic [1:0] RegPressLow  = 2'd1;
   localparam logic [1:0] RegPressHigh = 2'd2;
   localparam logic [1:0] RegPressLast = 2'd3;

   localparam logic signed [31:0] TempMul    = 32'sd5;
   localparam logic signed [31:0] TempRound  = 32'sd128;
   localparam logic signed [31:0] PressOfs   = 32'sd64000;
   localparam logic signed [31:0] P1Bias     = 32'sd32768;
   localparam logic [31:0]        RawFull    = 32'd1048576;
   localparam logic [31:0]        PressScale = 32'd3125;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } calib_type;

   typedef struct packed {
      logic [31:0] temp;
      logic        pok;
      logic        dbl;
   } side_type;

   function automatic logic signed [31:0] sext16(input logic [15:0] v);
      return $signed({{16{v[15]}}, v});
   endfunction

   function automatic logic signed [31:0] zext16(input logic [15:0] v);
      return $signed({16'd0, v});
   endfunction

endpackage

// ===== src/bsc_front.sv =====
// Temperature and pressure coefficient stages up to the divider operands.
module bsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [19:0]          raw_t,
   input  logic [19:0]          raw_p,
   input  bsc_pkg::calib_type   calib,
   output logic                 out_valid,
   output logic [31:0]          out_n,
   output logic [31:0]          out_d,
   output bsc_pkg::side_type    out_sb
);

   logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   logic [11:1] vld_ff;
   logic [19:0] adc_t_ff;
   logic [19:0] adc_p_ff [1:8];
   logic [31:0] temp_ff [5:10];
   logic signed [31:0] am_ff, dd_ff, a_ff, bm_ff, tf_ff, pa_ff, q_ff;
   logic signed [31:0] sq_ff, m5_ff, m2_ff, m5b_ff, m2b_ff, b1_ff, m3_ff;
   logic signed [31:0] b3_ff, a2_ff, a3_ff, div_ff;
   logic [31:0] pw_ff, pw2_ff;
   logic [31:0] n_ff, d_ff;
   bsc_pkg::side_type sb_ff;

   logic signed [31:0] adc_t32, x1, dv, am_in, dd_in, a_in, bm_in, tf_in;
   logic signed [31:0] tmp5, temp_in, pa_in, q_in, sq_in, m5_in, m2_in;
   logic signed [31:0] b1_in, m3_in, b2, b3_in, a2_in, a3_in;
   logic [31:0] pw_in, pw2_in;

   assign t1 = bsc_pkg::zext16(calib.t1);
   assign t2 = bsc_pkg::sext16(calib.t2);
   assign t3 = bsc_pkg::sext16(calib.t3);
   assign p1 = bsc_pkg::zext16(calib.p1);
   assign p2 = bsc_pkg::sext16(calib.p2);
   assign p3 = bsc_pkg::sext16(calib.p3);
   assign p4 = bsc_pkg::sext16(calib.p4);
   assign p5 = bsc_pkg::sext16(calib.p5);
   assign p6 = bsc_pkg::sext16(calib.p6);

   always_comb begin
      adc_t32 = $signed({12'd0, adc_t_ff});
      x1      = (adc_t32 >>> 3) - (t1 <<< 1);
      am_in   = x1 * t2;
      dv      = (adc_t32 >>> 4) - t1;
      dd_in   = dv * dv;
      a_in    = am_ff >>> 11;
      bm_in   = (dd_ff >>> 12) * t3;
      tf_in   = a_ff + (bm_ff >>> 14);
      tmp5    = tf_ff * bsc_pkg::TempMul + bsc_pkg::TempRound;
      temp_in = tmp5 >>> 8;
      pa_in   = (tf_ff >>> 1) - bsc_pkg::PressOfs;
      q_in    = pa_in >>> 2;
      sq_in   = q_ff * q_ff;
      m5_in   = pa_ff * p5;
      m2_in   = p2 * pa_ff;
      b1_in   = (sq_ff >>> 11) * p6;
      m3_in   = p3 * (sq_ff >>> 13);
      b2      = b1_ff + (m5b_ff <<< 1);
      b3_in   = (b2 >>> 2) + (p4 <<< 16);
      a2_in   = ((m3_ff >>> 3) + (m2b_ff >>> 1)) >>> 18;
      a3_in   = ((bsc_pkg::P1Bias + a2_ff) * p1) >>> 15;
      pw_in   = (bsc_pkg::RawFull - {12'd0, adc_p_ff[8]}) - $unsigned(b3_ff >>> 12);
      pw2_in  = pw_ff * bsc_pkg::PressScale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[10:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adc_t_ff    <= raw_t;
         adc_p_ff[1] <= raw_p;
         for (int i = 2; i <= 8; i++) begin
            adc_p_ff[i] <= adc_p_ff[i-1];
         end
         am_ff <= am_in;
         dd_ff <= dd_in;
         a_ff  <= a_in;
         bm_ff <= bm_in;
         tf_ff <= tf_in;
         temp_ff[5] <= temp_in;
         for (int i = 6; i <= 10; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         pa_ff  <= pa_in;
         q_ff   <= q_in;
         sq_ff  <= sq_in;
         m5_ff  <= m5_in;
         m2_ff  <= m2_in;
         m5b_ff <= m5_ff;
         m2b_ff <= m2_ff;
         b1_ff  <= b1_in;
         m3_ff  <= m3_in;
         b3_ff  <= b3_in;
         a2_ff  <= a2_in;
         a3_ff  <= a3_in;
         pw_ff  <= pw_in;
         pw2_ff <= pw2_in;
         div_ff <= a3_ff;
         n_ff   <= pw2_ff[31] ? pw2_ff : {pw2_ff[30:0], 1'b0};
         d_ff   <= div_ff;
         sb_ff.temp <= temp_ff[10];
         sb_ff.pok  <= (div_ff != 32'sd0);
         sb_ff.dbl  <= pw2_ff[31];
      end
   end

   assign out_valid = vld_ff[11];
   assign out_n     = n_ff;
   assign out_d     = d_ff;
   assign out_sb    = sb_ff;

endmodule

// ===== src/bsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module bsc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        in_n,
   input  logic [31:0]        in_d,
   input  bsc_pkg::side_type  in_sb,
   output logic               out_valid,
   output logic [31:0]        out_q,
   output bsc_pkg::side_type  out_sb
);

   logic [bsc_pkg::DivBits:1] vld_ff;
   logic [31:0] rem_ff [1:bsc_pkg::DivBits];
   logic [31:0] n_ff   [1:bsc_pkg::DivBits];
   logic [31:0] d_ff   [1:bsc_pkg::DivBits];
   bsc_pkg::side_type sb_ff [1:bsc_pkg::DivBits];

   logic [31:0] rem_src [0:bsc_pkg::DivBits-1];
   logic [31:0] n_src   [0:bsc_pkg::DivBits-1];
   logic [31:0] d_src   [0:bsc_pkg::DivBits-1];
   bsc_pkg::side_type sb_src [0:bsc_pkg::DivBits-1];
   logic [31:0] rem_in  [1:bsc_pkg::DivBits];
   logic [31:0] n_in    [1:bsc_pkg::DivBits];

   always_comb begin
      logic [32:0] rt;
      logic        ge;
      rem_src[0] = '0;
      n_src[0]   = in_n;
      d_src[0]   = in_d;
      sb_src[0]  = in_sb;
      for (int i = 1; i < bsc_pkg::DivBits; i++) begin
         rem_src[i] = rem_ff[i];
         n_src[i]   = n_ff[i];
         d_src[i]   = d_ff[i];
         sb_src[i]  = sb_ff[i];
      end
      for (int i = 0; i < bsc_pkg::DivBits; i++) begin
         rt = {rem_src[i], n_src[i][31]};
         ge = (rt >= {1'b0, d_src[i]});
         rem_in[i+1] = ge ? 32'(rt - {1'b0, d_src[i]}) : rt[31:0];
         n_in[i+1]   = {n_src[i][30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[bsc_pkg::DivBits-1:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 1; i <= bsc_pkg::DivBits; i++) begin
            rem_ff[i] <= rem_in[i];
            n_ff[i]   <= n_in[i];
            d_ff[i]   <= d_src[i-1];
            sb_ff[i]  <= sb_src[i-1];
         end
      end
   end

   assign out_valid = vld_ff[bsc_pkg::DivBits];
   assign out_q     = n_ff[bsc_pkg::DivBits];
   assign out_sb    = sb_ff[bsc_pkg::DivBits];

endmodule

// ===== src/bsc_back.sv =====
// Pressure correction stages after the divider and the result register.
module bsc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        in_q,
   input  bsc_pkg::side_type  in_sb,
   input  bsc_pkg::calib_type calib,
   output logic               out_valid,
   output logic [31:0]        out_temp,
   output logic [31:0]        out_press,
   output logic               out_pok
);

   logic signed [31:0] p7, p8, p9;
   logic [2:1] vld_ff;
   logic [31:0] p_ff [1:2];
   bsc_pkg::side_type sb_ff [1:2];
   logic [31:0] pw3_ff;
   logic signed [31:0] m8_ff, a_ff, b_ff;
   logic        rsp_valid_ff, rsp_pok_ff;
   logic [31:0] rsp_temp_ff, rsp_press_ff;

   logic [31:0] p_in, ps3, pw3_in, press;
   logic signed [31:0] m8_in, a_in, b_in, dsum;

   assign p7 = bsc_pkg::sext16(calib.p7);
   assign p8 = bsc_pkg::sext16(calib.p8);
   assign p9 = bsc_pkg::sext16(calib.p9);

   always_comb begin
      p_in   = in_sb.dbl ? {in_q[30:0], 1'b0} : in_q;
      ps3    = p_in >> 3;
      pw3_in = ps3 * ps3;
      m8_in  = $signed({2'd0, p_in[31:2]}) * p8;
      a_in   = (p9 * $signed({13'd0, pw3_ff[31:13]})) >>> 12;
      b_in   = m8_ff >>> 13;
      dsum   = ((a_ff + b_ff) + p7) >>> 4;
      press  = p_ff[2] + $unsigned(dsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[1], in_valid};
         rsp_valid_ff <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[1]  <= p_in;
         p_ff[2]  <= p_ff[1];
         sb_ff[1] <= in_sb;
         sb_ff[2] <= sb_ff[1];
         pw3_ff   <= pw3_in;
         m8_ff    <= m8_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         rsp_temp_ff  <= sb_ff[2].temp;
         rsp_press_ff <= sb_ff[2].pok ? press : 32'd0;
         rsp_pok_ff   <= sb_ff[2].pok;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_temp  = rsp_temp_ff;
   assign out_press = rsp_press_ff;
   assign out_pok   = rsp_pok_ff;

endmodule

// ===== src/barometric_sensor_compensation_unit.sv =====
// Barometric sensor compensation: top level with calibration registers.
//
// Usage:
//   req channel: one beat carries a raw 20-bit temperature and a raw 20-bit
//   pressure reading. rsp channel: one beat per request with the temperature
//   in 0.01 degree, the pressure in Pa and a flag that is clear when the
//   pressure divisor came out zero (pressure then reads 0).
//   csr port: write enable, 2-bit register index and 64-bit data; indexes
//   are temp_calib, press_calib_low, press_calib_high, press_calib_last.
//   Write calibration only while no beat is in flight.
// Timing:
//   A fixed 46-stage pipeline: 11 coefficient stages, 32 divider stages
//   (one quotient bit per stage) and 3 correction/output stages. One beat per
//   cycle is sustained while rsp is not stalled.
// Reset and stall:
//   Reset clears all valid bits and the calibration registers. When rsp is
//   stalled with a beat waiting, the whole pipeline freezes and req_stall is
//   raised in the same cycle; nothing is lost or repeated.
module barometric_sensor_compensation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_pa,
   output logic        rsp_pressure_valid,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [47:0] temp_calib_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [15:0] press_last_ff;
   bsc_pkg::calib_type calib;
   logic en;

   logic              f_valid;
   logic [31:0]       f_n, f_d;
   bsc_pkg::side_type f_sb;
   logic              d_valid;
   logic [31:0]       d_q;
   bsc_pkg::side_type d_sb;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_last_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bsc_pkg::RegTempCalib: temp_calib_ff <= csr_write_data[47:0];
            bsc_pkg::RegPressLow:  press_low_ff  <= csr_write_data;
            bsc_pkg::RegPressHigh: press_high_ff <= csr_write_data;
            bsc_pkg::RegPressLast: press_last_ff <= csr_write_data[15:0];
            default:               temp_calib_ff <= temp_calib_ff;
         endcase
      end
   end

   assign calib.t1 = temp_calib_ff[15:0];
   assign calib.t2 = temp_calib_ff[31:16];
   assign calib.t3 = temp_calib_ff[47:32];
   assign calib.p1 = press_low_ff[15:0];
   assign calib.p2 = press_low_ff[31:16];
   assign calib.p3 = press_low_ff[47:32];
   assign calib.p4 = press_low_ff[63:48];
   assign calib.p5 = press_high_ff[15:0];
   assign calib.p6 = press_high_ff[31:16];
   assign calib.p7 = press_high_ff[47:32];
   assign calib.p8 = press_high_ff[63:48];
   assign calib.p9 = press_last_ff;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .calib     (calib),
      .out_valid (f_valid),
      .out_n     (f_n),
      .out_d     (f_d),
      .out_sb    (f_sb)
   );

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_n      (f_n),
      .in_d      (f_d),
      .in_sb     (f_sb),
      .out_valid (d_valid),
      .out_q     (d_q),
      .out_sb    (d_sb)
   );

   bsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_q      (d_q),
      .in_sb     (d_sb),
      .calib     (calib),
      .out_valid (rsp_valid),
      .out_temp  (rsp_temperature_centi),
      .out_press (rsp_pressure_pa),
      .out_pok   (rsp_pressure_valid)
   );

endmodule

// ===== src/bsc_checker.sv =====
// Port-level checks for the compensation unit, bound to the top level.
module bsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_temperature_centi,
   input logic [31:0] rsp_pressure_pa,
   input logic        rsp_pressure_valid
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pressure_pa)
         && $stable(rsp_temperature_centi))
      else $error("stalled rsp beat changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output stall");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure_pa == 32'd0)
      else $error("invalid pressure is not zero");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind barometric_sensor_compensation_unit bsc_checker u_bsc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_temperature_centi (rsp_temperature_centi),
   .rsp_pressure_pa       (rsp_pressure_pa),
   .rsp_pressure_valid    (rsp_pressure_valid)
);

// ===== sim/barometric_sensor_compensation_unit_tb.sv =====
// Self-checking testbench for the barometric sensor compensation unit.
module barometric_sensor_compensation_unit_tb;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] press;
      logic        pvalid;
   } reading_type;

   typedef struct {
      int          calib_sel;
      bit [19:0]   raw_t;
      bit [19:0]   raw_p;
      bit          known;
      reading_type want;
   } stim_row_type;

   localparam int LatencyCycles = 46;
   localparam int CycleLimit    = 300000;
   localparam int RandomItems   = 1250;
   localparam int NumPhases     = 5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [19:0] req_raw_temperature;
   logic [19:0] req_raw_pressure;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_pressure_valid;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   // calibration copy used for prediction
   bit [47:0] cal_temp;
   bit [63:0] cal_press_low;
   bit [63:0] cal_press_high;
   bit [15:0] cal_press_last;

   reading_type expected_readings[$];
   int        sender_idle_pct;
   int        receiver_stall_pct;
   int        mismatches;
   int        readings_checked;
   int        invalid_pressures;
   int        cycle_count;

   barometric_sensor_compensation_unit DUT (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint w32(input longint x);
      return longint'(int'(x));
   endfunction

   function automatic longint s16(input bit [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic reading_type compensate(input bit [19:0] raw_t, input bit [19:0] raw_p);
      reading_type r;
      longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, b, d, tf, q, sq;
      bit [63:0] pw;
      bit [31:0] p, dv;
      adc_t = longint'(raw_t);
      adc_p = longint'(raw_p);
      t1 = longint'(cal_temp[15:0]);
      t2 = s16(cal_temp[31:16]);
      t3 = s16(cal_temp[47:32]);
      p1 = longint'(cal_press_low[15:0]);
      p2 = s16(cal_press_low[31:16]);
      p3 = s16(cal_press_low[47:32]);
      p4 = s16(cal_press_low[63:48]);
      p5 = s16(cal_press_high[15:0]);
      p6 = s16(cal_press_high[31:16]);
      p7 = s16(cal_press_high[47:32]);
      p8 = s16(cal_press_high[63:48]);
      p9 = s16(cal_press_last);

      a = w32(w32((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
      d = (adc_t >>> 4) - t1;
      b = w32((w32(d * d) >>> 12) * t3) >>> 14;
      tf = w32(a + b);
      r.temp = 32'(w32(tf * 5 + 128) >>> 8);

      a = w32((tf >>> 1) - 64000);
      q = a >>> 2;
      sq = w32(q * q);
      b = w32((sq >>> 11) * p6);
      b = w32(b + w32(w32(a * p5) * 2));
      b = w32((b >>> 2) + w32(p4 * 65536));
      a = w32((w32(p3 * (sq >>> 13)) >>> 3) + (w32(p2 * a) >>> 1)) >>> 18;
      a = w32((32768 + a) * p1) >>> 15;
      if (a == 0) begin
         r.press = '0;
         r.pvalid = 1'b0;
         return r;
      end
      dv = 32'(a);
      pw = 64'((1048576 - adc_p) - (b >>> 12));
      pw = {32'd0, pw[31:0]} * 64'd3125;
      p = pw[31:0];
      if (p < 32'h8000_0000) begin
         p = {p[30:0], 1'b0} / dv;
      end else begin
         p = (p / dv) << 1;
      end
      pw = {32'd0, p >> 3} * {32'd0, p >> 3};
      a = w32(p9 * longint'(pw[31:13])) >>> 12;
      b = w32(longint'(p >> 2) * p8) >>> 13;
      d = w32(w32(a + b) + p7) >>> 4;
      r.press = p + 32'(d);
      r.pvalid = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat on rsp");
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            if (!want.pvalid) invalid_pressures++;
            if (rsp_temperature_centi !== want.temp || rsp_pressure_pa !== want.press
                || rsp_pressure_valid !== want.pvalid) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp T=%0d P=%0d V=%b got T=%0d P=%0d V=%b",
                     $signed(want.temp), want.press, want.pvalid,
                     $signed(rsp_temperature_centi), rsp_pressure_pa, rsp_pressure_valid);
               end
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic drain();
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         bsc_pkg::RegTempCalib: cal_temp = data[47:0];
         bsc_pkg::RegPressLow:  cal_press_low = data;
         bsc_pkg::RegPressHigh: cal_press_high = data;
         bsc_pkg::RegPressLast: cal_press_last = data[15:0];
         default: ;
      endcase
   endtask

   // 0: reset values, 1: typical part, 2: all ones, 3: signed extremes, 4: random
   task automatic load_calib(input int sel);
      logic [63:0] tc, pl, ph, pz;
      case (sel)
         1: begin
            tc = {16'hFC18, 16'd26435, 16'd27504};
            pl = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
            ph = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
            pz = 64'd6000;
         end
         2: begin
            tc = '1; pl = '1; ph = '1; pz = '1;
         end
         3: begin
            tc = {16'h0, 16'h8000, 16'h8000, 16'hFFFF};
            pl = {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
            ph = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
            pz = {48'h0, 16'h8000};
         end
         4: begin
            tc = {$urandom, $urandom};
            pl = {$urandom, $urandom};
            ph = {$urandom, $urandom};
            pz = {$urandom, $urandom};
         end
         default: begin
            tc = '0; pl = '0; ph = '0; pz = '0;
         end
      endcase
      drain();
      csr_write(bsc_pkg::RegTempCalib, tc);
      csr_write(bsc_pkg::RegPressLow, pl);
      csr_write(bsc_pkg::RegPressHigh, ph);
      csr_write(bsc_pkg::RegPressLast, pz);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send(input bit [19:0] raw_t, input bit [19:0] raw_p);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure <= raw_p;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      int cur_sel;
      bit [19:0] rt, rp;
      reading_type zero_reading;

      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = bsc_pkg::RegTempCalib;
      csr_write_data = '0;
      cal_temp = '0;
      cal_press_low = '0;
      cal_press_high = '0;
      cal_press_last = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      mismatches = 0;
      readings_checked = 0;
      invalid_pressures = 0;
      cycle_count = 0;
      zero_reading = '{temp: '0, press: '0, pvalid: 1'b0};

      // zero calibration: temperature 0, divisor zero so pressure flagged invalid
      rows.push_back('{0, 20'h00000, 20'h00000, 1, zero_reading});
      rows.push_back('{0, 20'hFFFFF, 20'hFFFFF, 1, zero_reading});
      rows.push_back('{0, 20'h00000, 20'hFFFFF, 1, zero_reading});
      rows.push_back('{0, 20'hFFFFF, 20'h00000, 1, zero_reading});
      rows.push_back('{0, 20'hAAAAA, 20'h55555, 1, zero_reading});
      rows.push_back('{1, 20'd519888, 20'd415148, 0, zero_reading});
      rows.push_back('{1, 20'h00000, 20'h00000, 0, zero_reading});
      rows.push_back('{1, 20'hFFFFF, 20'hFFFFF, 0, zero_reading});
      rows.push_back('{1, 20'hFFFFF, 20'h00000, 0, zero_reading});
      rows.push_back('{1, 20'h00000, 20'hFFFFF, 0, zero_reading});
      rows.push_back('{1, 20'h55555, 20'hAAAAA, 0, zero_reading});
      rows.push_back('{1, 20'h00001, 20'h80000, 0, zero_reading});
      rows.push_back('{2, 20'h00000, 20'h00000, 0, zero_reading});
      rows.push_back('{2, 20'hFFFFF, 20'hFFFFF, 0, zero_reading});
      rows.push_back('{2, 20'd519888, 20'd415148, 0, zero_reading});
      rows.push_back('{3, 20'h00000, 20'hFFFFF, 0, zero_reading});
      rows.push_back('{3, 20'hFFFFF, 20'h00000, 0, zero_reading});
      rows.push_back('{3, 20'd519888, 20'd415148, 0, zero_reading});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_sel = 0;
      foreach (rows[i]) begin
         row = rows[i];
         if (row.calib_sel != cur_sel) begin
            req_valid <= 1'b0;
            load_calib(row.calib_sel);
            cur_sel = row.calib_sel;
         end
         // known rows: the expected beat is pinned, checked against the predictor's
         if (row.known) begin
            if (compensate(row.raw_t, row.raw_p) != row.want) begin
               mismatches++;
               $display("table row %0d disagrees with prediction", i);
            end
         end
         send(row.raw_t, row.raw_p);
      end

      for (int ph = 0; ph < NumPhases; ph++) begin
         req_valid <= 1'b0;
         load_calib((ph == 0) ? 1 : (ph == 3) ? 0 : 4);
         sender_idle_pct    = (ph == 1 || ph == 4) ? 82 : (ph == 3) ? 13 : 0;
         receiver_stall_pct = (ph == 2 || ph == 4) ? 82 : (ph == 3) ? 13 : 0;
         for (int n = 0; n < RandomItems / NumPhases; n++) begin
            if (n == 100) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (expected_readings.size() != 0) @(posedge clock);
            end
            if ($urandom_range(1)) begin
               rt = 20'($urandom_range(540000, 480000));
               rp = 20'($urandom_range(480000, 250000));
            end else begin
               rt = 20'($urandom);
               rp = 20'($urandom);
            end
            send(rt, rp);
            // stretches with no idling
            if (n % 50 == 25) begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            if (n % 50 == 40) begin
               sender_idle_pct    = (ph == 1 || ph == 4) ? 82 : (ph == 3) ? 13 : 0;
               receiver_stall_pct = (ph == 2 || ph == 4) ? 82 : (ph == 3) ? 13 : 0;
            end
         end
      end
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      drain();

      $display("checked %0d compensated readings (%0d with zero divisor) over %0d calib sets",
         readings_checked, invalid_pressures, NumPhases + 3);
      $display("idle patterns: none, sender, receiver, both; %0d mismatches", mismatches);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
